### hdl/cdav_pkg.sv
// ----------------------------------------------------------------------------
// cdav_pkg
// Shared constants and controller/datapath interface types for the
// dirty-aware clock victim selector.
// ----------------------------------------------------------------------------
package cdav_pkg;

  localparam int MODE_W     = 2;
  localparam int PORT_IDX_W = 6;
  localparam int CFG_W      = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [MODE_W-1:0] MODE_ACCESS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VICTIM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // slots examined per scan cycle
  localparam int CHUNK   = 8;
  localparam int CHUNK_W = 3;

  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_is_victim;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

### hdl/cdav_ctrl.sv
// ----------------------------------------------------------------------------
// cdav_ctrl
// Sequencer: takes a word, runs the chunked scan for victim requests and
// finishes the word once the result register is free.
// ----------------------------------------------------------------------------
module cdav_ctrl import cdav_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = st.in_is_victim ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready   = (state == S_IDLE) && !rst;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.finish = (state == S_DONE);

endmodule

### hdl/cdav_dp.sv
// ----------------------------------------------------------------------------
// cdav_dp
// Datapath: frame flag vectors, clock hand, chunked rotated search,
// flag update and the result register.
// ----------------------------------------------------------------------------
module cdav_dp import cdav_pkg::*; #(
  parameter int FRAME_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [MODE_W-1:0]     mode,
  input  logic [PORT_IDX_W-1:0] frame_index,
  input  logic                  is_write,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  victim_valid,
  output logic [PORT_IDX_W-1:0] victim_index,
  output logic                  victim_was_empty,
  output logic                  victim_was_dirty
);

  localparam int IDX_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CNT_W  = $clog2(FRAME_SLOTS + 1);
  localparam int NCHUNK = (FRAME_SLOTS + CHUNK - 1) / CHUNK;
  localparam int PADN   = NCHUNK * CHUNK;
  localparam int CI_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = $clog2(PADN);
  localparam int CW     = (CNT_W > PAD_W) ? CNT_W : PAD_W;
  localparam int XW     = (CW > PORT_IDX_W) ? CW : PORT_IDX_W;

  logic [CFG_W-1:0]       frames_in_use;
  logic [IDX_W-1:0]       hand;
  logic [FRAME_SLOTS-1:0] occ, acc, dirty;
  logic [FRAME_SLOTS-1:0] occ_next, acc_next, dirty_next;

  logic [MODE_W-1:0]      req_mode;
  logic [PORT_IDX_W-1:0]  req_index;
  logic                   req_write;
  logic [IDX_W-1:0]       start;
  logic [CI_W-1:0]        ci;
  logic                   pass_b;
  logic [IDX_W-1:0]       victim;
  logic                   found;

  logic [CNT_W-1:0]       n;
  logic [IDX_W-1:0]       start_c;
  logic [CI_W-1:0]        cs, lastc;
  logic [PADN-1:0]        occ_p, acc_p, dirty_p;
  logic [CHUNK-1:0]       occ_c, acc_c, dirty_c, qual;
  logic                   hit;
  logic [CHUNK_W-1:0]     hit_j;
  logic [IDX_W-1:0]       hit_pos;
  logic                   scan_final;
  logic                   out_free, do_fin, idx_ok;
  logic [IDX_W-1:0]       slot;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] p,
                                           input logic [CNT_W-1:0] cnt);
    logic [CW-1:0] s;
    s = CW'(p) + CW'(1);
    adv = (s >= CW'(cnt)) ? '0 : IDX_W'(s);
  endfunction

  // clamped active count
  always_comb begin
    if (frames_in_use == '0) begin
      n = CNT_W'(1);
    end else if (32'(frames_in_use) > FRAME_SLOTS) begin
      n = CNT_W'(FRAME_SLOTS);
    end else begin
      n = CNT_W'(frames_in_use);
    end
  end

  assign start_c = (CW'(hand) < CW'(n)) ? hand : '0;
  assign cs      = CI_W'(start >> CHUNK_W);
  assign lastc   = CI_W'((CW'(n) - CW'(1)) >> CHUNK_W);

  always_comb begin
    occ_p                    = '0;
    acc_p                    = '0;
    dirty_p                  = '0;
    occ_p[FRAME_SLOTS-1:0]   = occ;
    acc_p[FRAME_SLOTS-1:0]   = acc;
    dirty_p[FRAME_SLOTS-1:0] = dirty;
  end

  assign occ_c   = occ_p[ci*CHUNK +: CHUNK];
  assign acc_c   = acc_p[ci*CHUNK +: CHUNK];
  assign dirty_c = dirty_p[ci*CHUNK +: CHUNK];

  // candidates in the current chunk: empty, or clean and unaccessed
  always_comb begin
    logic [CW-1:0] pos_j;
    logic          win_ok;
    qual = '0;
    for (int j = 0; j < CHUNK; j++) begin
      pos_j   = (CW'(ci) << CHUNK_W) | CW'(j);
      win_ok  = pass_b ? (pos_j < CW'(start)) : (pos_j >= CW'(start));
      qual[j] = win_ok && (pos_j < CW'(n)) && (!occ_c[j] || (!acc_c[j] && !dirty_c[j]));
    end
  end

  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (qual[j]) begin
        hit   = 1'b1;
        hit_j = CHUNK_W'(j);
      end
    end
  end

  assign hit_pos    = IDX_W'((CW'(ci) << CHUNK_W) | CW'(hit_j));
  assign scan_final = pass_b && (ci == cs);

  assign out_free = !out_valid || out_ready;
  assign do_fin   = cmd.finish && out_free;
  assign idx_ok   = XW'(req_index) < XW'(n);
  assign slot     = IDX_W'(req_index);

  assign st.in_is_victim = (mode == MODE_VICTIM);
  assign st.scan_done    = hit || scan_final;
  assign st.out_free     = out_free;

  // flag updates, applied when the word finishes
  always_comb begin
    logic [IDX_W-1:0] iv;
    logic             passed;
    iv         = '0;
    passed     = 1'b0;
    occ_next   = occ;
    acc_next   = acc;
    dirty_next = dirty;
    if (do_fin) begin
      unique case (req_mode)
        MODE_ACCESS: begin
          if (idx_ok && occ[slot]) begin
            acc_next[slot] = 1'b1;
            if (req_write) begin
              dirty_next[slot] = 1'b1;
            end
          end
        end
        MODE_RELEASE: begin
          if (idx_ok) begin
            occ_next[slot]   = 1'b0;
            acc_next[slot]   = 1'b0;
            dirty_next[slot] = 1'b0;
          end
        end
        MODE_VICTIM: begin
          // second chance taken by every slot the hand swept past
          for (int i = 0; i < FRAME_SLOTS; i++) begin
            iv = IDX_W'(i);
            if (!found) begin
              passed = 1'b1;
            end else if (victim >= start) begin
              passed = (iv >= start) && (iv < victim);
            end else begin
              passed = (iv >= start) || (iv < victim);
            end
            if ((CNT_W'(i) < n) && passed) begin
              acc_next[i] = 1'b0;
            end
          end
          occ_next[victim]   = 1'b1;
          acc_next[victim]   = 1'b0;
          dirty_next[victim] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
      hand          <= '0;
      occ           <= '0;
      acc           <= '0;
      dirty         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        frames_in_use <= cfg_wdata;
      end
      occ   <= occ_next;
      acc   <= acc_next;
      dirty <= dirty_next;
      if (do_fin && (req_mode == MODE_VICTIM)) begin
        hand <= adv(victim, n);
      end
      if (do_fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and scan registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode  <= mode;
      req_index <= frame_index;
      req_write <= is_write;
      start     <= start_c;
      ci        <= CI_W'(start_c >> CHUNK_W);
      pass_b    <= 1'b0;
    end else if (cmd.scan) begin
      if (hit) begin
        victim <= hit_pos;
        found  <= 1'b1;
      end else if (scan_final) begin
        victim <= adv(start, n);
        found  <= 1'b0;
      end else if (!pass_b && (ci == lastc)) begin
        pass_b <= 1'b1;
        ci     <= '0;
      end else begin
        ci <= ci + CI_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (do_fin) begin
      if (req_mode == MODE_VICTIM) begin
        victim_valid     <= 1'b1;
        victim_index     <= PORT_IDX_W'(victim);
        victim_was_empty <= !occ[victim];
        victim_was_dirty <= occ[victim] && dirty[victim];
      end else begin
        victim_valid     <= 1'b0;
        victim_index     <= '0;
        victim_was_empty <= 1'b0;
        victim_was_dirty <= 1'b0;
      end
    end
  end

endmodule

### hdl/clock_dirty_aware_victim_select.sv
// ----------------------------------------------------------------------------
// clock_dirty_aware_victim_select
// Enhanced second-chance clock replacement with dirty awareness: tracks
// occupied, accessed and dirty flags per frame slot and picks victims.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   mode, frame_index, is_write
//   out      output     out_valid / out_ready victim_valid, victim_index,
//                                             victim_was_empty, victim_was_dirty
//   cfg      input      cfg_wen               cfg_wdata (frames_in_use)
//
// Access, release and unused words go from accept straight to the finish
// step; victim requests first run the search, which examines one group of 8
// slots of the flag vectors per cycle, at most one pass over the groups from
// the hand, wrapping once.
// One word in flight; the next is accepted while the result waits in the
// output register, and a stalled output holds the finishing word.
// Synchronous reset empties all slots and returns the hand to slot zero.
// ----------------------------------------------------------------------------
module clock_dirty_aware_victim_select import cdav_pkg::*; #(
  parameter int FRAME_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     mode,
  input  logic [PORT_IDX_W-1:0] frame_index,
  input  logic                  is_write,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  victim_valid,
  output logic [PORT_IDX_W-1:0] victim_index,
  output logic                  victim_was_empty,
  output logic                  victim_was_dirty
);

  cmd_t  cmd;
  stat_t st;

  cdav_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  cdav_dp #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata),
    .mode             (mode),
    .frame_index      (frame_index),
    .is_write         (is_write),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .victim_valid     (victim_valid),
    .victim_index     (victim_index),
    .victim_was_empty (victim_was_empty),
    .victim_was_dirty (victim_was_dirty)
  );

endmodule

### hdl/cdav_checker.sv
// ----------------------------------------------------------------------------
// cdav_checker
// Port-level checks for the victim selector, bound to the top level.
// ----------------------------------------------------------------------------
module cdav_checker import cdav_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  victim_valid,
  input logic [PORT_IDX_W-1:0] victim_index,
  input logic                  victim_was_empty,
  input logic                  victim_was_dirty
);

  // one word in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in flight");

  // a fresh result only comes from a word in flight
  a_result_from_word: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no word in flight");

  a_non_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !victim_valid) |->
      (victim_index == '0) && !victim_was_empty && !victim_was_dirty)
    else $error("non-victim word carries victim fields");

  // an empty slot cannot need writeback
  a_empty_not_dirty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(victim_was_empty && victim_was_dirty))
    else $error("victim reported both empty and dirty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(victim_index))
    else $error("stalled result dropped or changed");

endmodule

bind clock_dirty_aware_victim_select cdav_checker u_cdav_checker (.*);
